@@ sv/mrfc_pkg.sv @@
// Shared constants and types for the motor reply frame checker.
package mrfc_pkg;

  // Frame length limits; a saturated count always reads as too long.
  localparam int unsigned MaxFrameBytes = 32;
  localparam int unsigned MinFrameBytes = 4;
  localparam int unsigned HeadBytes     = 8;
  localparam int unsigned CountWidth    = 6;
  localparam logic [CountWidth-1:0] CountMax = {CountWidth{1'b1}};

  // Byte values that carry meaning on the link.
  localparam logic [7:0] CheckByte     = 8'h6B;
  localparam logic [7:0] CodeOptions   = 8'h1A;
  localparam logic [7:0] CodeStatus    = 8'h3A;
  localparam logic [7:0] CodePosition  = 8'h36;
  localparam logic [7:0] CodeVersion   = 8'h1F;
  localparam logic [7:0] CodeMove      = 8'hFD;
  localparam logic [7:0] CodeStop      = 8'hFE;
  localparam logic [7:0] DevParamErr   = 8'hE2;
  localparam logic [7:0] DevFormatErr  = 8'hEE;
  localparam logic [7:0] ReplyAck      = 8'h02;
  localparam logic [7:0] ReplyReached  = 8'h9F;
  localparam logic [7:0] StatusResMask = 8'h40;
  localparam logic [7:0] NibbleMask    = 8'h0F;

  // Configuration register indexes.
  localparam logic CfgExpAddress  = 1'b0;
  localparam logic CfgExpFunction = 1'b1;

  typedef enum logic [1:0] {
    StOk     = 2'd0,
    StProto  = 2'd1,
    StDevice = 2'd2
  } frame_status_e;

  typedef enum logic [3:0] {
    KindNone     = 4'd0,
    KindOptions  = 4'd1,
    KindStatus   = 4'd2,
    KindPosition = 4'd3,
    KindVersion  = 4'd4,
    KindAck      = 4'd5,
    KindReached  = 4'd6,
    KindParam    = 4'd7,
    KindFormat   = 4'd8
  } reply_kind_e;

  // One decoded result item.
  typedef struct packed {
    logic [7:0]    hw_revision;
    logic [3:0]    hw_variant;
    logic [3:0]    hw_family;
    logic          position_negative;
    logic [31:0]   word_value;
    logic [7:0]    reply_function;
    logic [7:0]    reply_address;
    reply_kind_e   reply_kind;
    frame_status_e frame_status;
  } result_t;

endpackage

@@ sv/motor_reply_frame_checker.sv @@
// Motor reply frame checker: collects reply bytes and decodes each finished frame.
//
// The slave stream carries one received byte per transaction in s_axis_tdata,
// with s_axis_tlast high on the last byte of a frame. For every frame the
// master stream gives exactly one result transaction: status and reply kind
// in m_axis_tuser, address, function and payload fields in m_axis_tdata.
// Bytes that are not the last of a frame give no result.
//
// One byte is taken per cycle while s_axis_tready is high. The byte updates
// the count and the stored head and last bytes; a last byte also latches the
// frame length into a decode stage, and the decode logic fills the output
// register from it once that register is free. The decode stage and output
// register keep back-to-back frames at full rate; when the receiver stalls
// with both full, s_axis_tready drops until m_axis_tready returns.
//
// Expected address and function must be written through the cfg port only while no
// frame is in flight; the block does not enforce this. Reset empties the pipeline,
// clears the byte count and restores address 1 and function 0x3A.
module motor_reply_frame_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Configuration write port
  input  logic        cfg_we_i,
  input  logic        cfg_index_i,
  input  logic [7:0]  cfg_wdata_i,
  // Byte stream in
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
  input  logic        s_axis_tlast,   // frame_end
  // Result stream out
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [7:0] reply_address, [15:8] reply_function, [47:16] word_value,
  // [48] position_negative, [52:49] hw_family, [56:53] hw_variant,
  // [64:57] hw_revision, [71:65] zero
  output logic [71:0] m_axis_tdata,
  // [1:0] frame_status, [5:2] reply_kind
  output logic [5:0]  m_axis_tuser
);

  localparam int unsigned CW = mrfc_pkg::CountWidth;

  logic [7:0]    exp_addr_q;
  logic [7:0]    exp_func_q;
  logic [CW-1:0] count_q;
  logic [CW-1:0] count_inc;
  logic [7:0]    head_q [mrfc_pkg::HeadBytes];
  logic [7:0]    final_q;
  logic          pend_q;
  logic [CW-1:0] len_q;
  logic          out_valid_q;
  mrfc_pkg::result_t out_q;
  mrfc_pkg::result_t res_d;

  logic out_free;
  logic out_load;
  logic in_acc;

  // Handshake: the decode stage drains whenever the output register is free.
  assign out_free      = !out_valid_q || m_axis_tready;
  assign out_load      = pend_q && out_free;
  assign s_axis_tready = !pend_q || out_free;
  assign in_acc        = s_axis_tvalid && s_axis_tready;

  assign count_inc = (count_q == mrfc_pkg::CountMax) ? count_q : count_q + CW'(1);

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      exp_addr_q <= 8'd1;
      exp_func_q <= mrfc_pkg::CodeStatus;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        mrfc_pkg::CfgExpAddress:  exp_addr_q <= cfg_wdata_i;
        mrfc_pkg::CfgExpFunction: exp_func_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Byte count and decode-stage control.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      pend_q  <= 1'b0;
    end else begin
      if (out_load) begin
        pend_q <= 1'b0;
      end
      if (in_acc) begin
        if (s_axis_tlast) begin
          count_q <= '0;
          pend_q  <= 1'b1;
        end else begin
          count_q <= count_inc;
        end
      end
    end
  end

  // Frame bytes and latched length.
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      if (count_q < CW'(mrfc_pkg::HeadBytes)) begin
        head_q[count_q[2:0]] <= s_axis_tdata;
      end
      final_q <= s_axis_tdata;
      if (s_axis_tlast) begin
        len_q <= count_inc;
      end
    end
  end

  // Frame decode from the stored bytes.
  always_comb begin
    logic       len_ok;
    logic       hdr_ok;
    logic       dev_err;
    logic [7:0] b2;
    logic       short4;

    b2      = head_q[2];
    dev_err = (b2 == mrfc_pkg::DevParamErr) || (b2 == mrfc_pkg::DevFormatErr);
    short4  = (len_q == CW'(4));
    len_ok  = (len_q >= CW'(mrfc_pkg::MinFrameBytes)) &&
              (len_q <= CW'(mrfc_pkg::MaxFrameBytes));
    hdr_ok  = (head_q[0] == exp_addr_q) && (head_q[1] == exp_func_q) &&
              (final_q == mrfc_pkg::CheckByte);

    res_d              = '0;
    res_d.frame_status = mrfc_pkg::StProto;
    res_d.reply_kind   = mrfc_pkg::KindNone;

    if (len_ok && hdr_ok) begin
      res_d.reply_address  = head_q[0];
      res_d.reply_function = head_q[1];
      case (exp_func_q)
        mrfc_pkg::CodeOptions, mrfc_pkg::CodeStatus, mrfc_pkg::CodePosition,
        mrfc_pkg::CodeVersion: begin
          if (short4 && dev_err) begin
            res_d.frame_status = mrfc_pkg::StDevice;
            res_d.reply_kind   = (b2 == mrfc_pkg::DevParamErr) ?
                                 mrfc_pkg::KindParam : mrfc_pkg::KindFormat;
          end else if (exp_func_q == mrfc_pkg::CodeOptions) begin
            if (len_q == CW'(5)) begin
              res_d.frame_status = mrfc_pkg::StOk;
              res_d.reply_kind   = mrfc_pkg::KindOptions;
              res_d.word_value   = {16'd0, head_q[2], head_q[3]};
            end
          end else if (exp_func_q == mrfc_pkg::CodeStatus) begin
            if (short4 && ((b2 & mrfc_pkg::StatusResMask) == 8'd0)) begin
              res_d.frame_status = mrfc_pkg::StOk;
              res_d.reply_kind   = mrfc_pkg::KindStatus;
              res_d.word_value   = {24'd0, b2};
            end
          end else if (exp_func_q == mrfc_pkg::CodePosition) begin
            if ((len_q == CW'(8)) && (b2[7:1] == 7'd0)) begin
              res_d.frame_status      = mrfc_pkg::StOk;
              res_d.reply_kind        = mrfc_pkg::KindPosition;
              res_d.word_value        = {head_q[3], head_q[4], head_q[5], head_q[6]};
              res_d.position_negative = b2[0];
            end
          end else begin
            if (len_q == CW'(7)) begin
              res_d.frame_status = mrfc_pkg::StOk;
              res_d.reply_kind   = mrfc_pkg::KindVersion;
              res_d.word_value   = {16'd0, head_q[2], head_q[3]};
              res_d.hw_family    = head_q[4][7:4];
              res_d.hw_variant   = 4'(head_q[4] & mrfc_pkg::NibbleMask);
              res_d.hw_revision  = head_q[5];
            end
          end
        end
        mrfc_pkg::CodeMove, mrfc_pkg::CodeStop: begin
          if (short4) begin
            if (b2 == mrfc_pkg::ReplyAck) begin
              res_d.frame_status = mrfc_pkg::StOk;
              res_d.reply_kind   = mrfc_pkg::KindAck;
            end else if (dev_err) begin
              res_d.frame_status = mrfc_pkg::StDevice;
              res_d.reply_kind   = (b2 == mrfc_pkg::DevParamErr) ?
                                   mrfc_pkg::KindParam : mrfc_pkg::KindFormat;
            end else if ((b2 == mrfc_pkg::ReplyReached) &&
                         (exp_func_q == mrfc_pkg::CodeMove)) begin
              res_d.frame_status = mrfc_pkg::StOk;
              res_d.reply_kind   = mrfc_pkg::KindReached;
            end
          end
        end
        default: ;
      endcase
    end
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_q <= res_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = {out_q.reply_kind, out_q.frame_status};
  assign m_axis_tdata  = {7'd0, out_q.hw_revision, out_q.hw_variant,
                          out_q.hw_family, out_q.position_negative,
                          out_q.word_value, out_q.reply_function,
                          out_q.reply_address};

endmodule

@@ sim/tb_motor_reply_frame_checker.sv @@
// Testbench for the motor reply frame checker: byte stream in, replies checked by a predictor.
`timescale 1ns / 100ps

module tb_motor_reply_frame_checker;
  import mrfc_pkg::*;

  localparam int unsigned StallLimit = 2000;
  localparam int unsigned ByteTarget = 600;

  // One row of the directed table: setup, frame bytes (byte 0 lowest) and,
  // where it is obvious, the reply typed in by hand.
  typedef struct packed {
    logic [7:0]  addr;
    logic [7:0]  func;
    logic [3:0]  len;
    logic [63:0] bytes;
    logic        typed;
    result_t     want;
  } dir_row_t;

  localparam result_t RejectAll = '{8'h00, 4'h0, 4'h0, 1'b0, 32'h0, 8'h00, 8'h00,
                                    KindNone, StProto};
  localparam result_t StatusFmtErr = '{8'h00, 4'h0, 4'h0, 1'b0, 32'h0, CodeStatus, 8'h01,
                                       KindFormat, StDevice};

  localparam dir_row_t DirTable [8] = '{
    // Single byte frame: too short.
    '{8'h01, CodeStatus,   4'd1, 64'h0000_0000_0000_00FF, 1'b1, RejectAll},
    // Status reply with all flags clear.
    '{8'h01, CodeStatus,   4'd4, 64'h0000_0000_6B00_3A01, 1'b0, '0},
    // Status request answered by a format error byte.
    '{8'h01, CodeStatus,   4'd4, 64'h0000_0000_6BEE_3A01, 1'b1, StatusFmtErr},
    // Status reply with the reserved bit set.
    '{8'h01, CodeStatus,   4'd4, 64'h0000_0000_6B40_3A01, 1'b0, '0},
    // Options reply at the top address with all flags set.
    '{8'hFF, CodeOptions,  4'd5, 64'h0000_006B_FFFF_1AFF, 1'b0, '0},
    // Move reply: target reached.
    '{8'h00, CodeMove,     4'd4, 64'h0000_0000_6B9F_FD00, 1'b0, '0},
    // Stop reply does not accept the reached code.
    '{8'h00, CodeStop,     4'd4, 64'h0000_0000_6B9F_FE00, 1'b0, '0},
    // Stop acknowledge with a broken check byte.
    '{8'h00, CodeStop,     4'd4, 64'h0000_0000_6A02_FE00, 1'b1, RejectAll}
  };

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        cfg_we_i      = 1'b0;
  logic        cfg_index_i   = CfgExpAddress;
  logic [7:0]  cfg_wdata_i   = 8'h00;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata  = 8'h00;
  logic        s_axis_tlast  = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [71:0] m_axis_tdata;
  logic [5:0]  m_axis_tuser;

  // Predictor state: setup registers and the frame collected so far.
  logic [7:0]            want_addr = 8'h01;
  logic [7:0]            want_func = CodeStatus;
  logic [CountWidth-1:0] rx_count  = '0;
  logic [7:0]            head_q [HeadBytes];
  logic [7:0]            tail_byte;

  result_t     pending_replies [$];
  logic [7:0]  frame_buf [$];
  result_t     seen_reply;
  result_t     oldest_reply;
  int unsigned mismatches  = 0;
  int unsigned bytes_sent  = 0;
  int unsigned burst_left  = 0;
  int unsigned idle_cycles = 0;
  int unsigned mode_left   = 0;
  int unsigned stall_mode  = 0;
  logic [1:0]  stall_phase = 2'd0;

  motor_reply_frame_checker dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Decodes the collected frame of the given length under the current setup.
  function automatic result_t decode_reply(input int unsigned len);
    result_t    r;
    logic [7:0] b2;
    logic       dev_err;
    r = RejectAll;
    if (len < MinFrameBytes || len > MaxFrameBytes) return r;
    if (head_q[0] != want_addr || head_q[1] != want_func || tail_byte != CheckByte) return r;
    r.reply_address  = head_q[0];
    r.reply_function = head_q[1];
    b2 = head_q[2];
    dev_err = (b2 == DevParamErr) || (b2 == DevFormatErr);
    // Query replies take a device error only as a bare four-byte frame.
    if (len == 4 && dev_err && (want_func == CodeOptions || want_func == CodeStatus ||
                                want_func == CodePosition || want_func == CodeVersion)) begin
      r.frame_status = StDevice;
      r.reply_kind   = (b2 == DevParamErr) ? KindParam : KindFormat;
      return r;
    end
    case (want_func)
      CodeOptions: begin
        if (len == 5) begin
          r.frame_status = StOk;
          r.reply_kind   = KindOptions;
          r.word_value   = {16'h0, head_q[2], head_q[3]};
        end
      end
      CodeStatus: begin
        if (len == 4 && (b2 & StatusResMask) == 8'h00) begin
          r.frame_status = StOk;
          r.reply_kind   = KindStatus;
          r.word_value   = {24'h0, b2};
        end
      end
      CodePosition: begin
        if (len == 8 && b2 <= 8'd1) begin
          r.frame_status      = StOk;
          r.reply_kind        = KindPosition;
          r.word_value        = {head_q[3], head_q[4], head_q[5], head_q[6]};
          r.position_negative = b2[0];
        end
      end
      CodeVersion: begin
        if (len == 7) begin
          r.frame_status = StOk;
          r.reply_kind   = KindVersion;
          r.word_value   = {16'h0, head_q[2], head_q[3]};
          r.hw_family    = head_q[4][7:4];
          r.hw_variant   = head_q[4][3:0];
          r.hw_revision  = head_q[5];
        end
      end
      CodeMove, CodeStop: begin
        if (len == 4) begin
          if (b2 == ReplyAck) begin
            r.frame_status = StOk;
            r.reply_kind   = KindAck;
          end else if (dev_err) begin
            r.frame_status = StDevice;
            r.reply_kind   = (b2 == DevParamErr) ? KindParam : KindFormat;
          end else if (b2 == ReplyReached && want_func == CodeMove) begin
            r.frame_status = StOk;
            r.reply_kind   = KindReached;
          end
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  // Offers one byte, waits for its transaction and updates the predictor.
  task automatic send_byte(input logic [7:0] b, input logic last, input logic typed,
                           input result_t want);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, ($urandom_range(0, 3) == 0) ? 40 : 8);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tlast  <= last;
    do @(posedge clk_i); while (!s_axis_tready);
    burst_left--;
    bytes_sent++;
    if (rx_count < HeadBytes) head_q[rx_count[2:0]] = b;
    tail_byte = b;
    if (rx_count != CountMax) rx_count++;
    if (last) begin
      pending_replies.push_back(typed ? want : decode_reply(rx_count));
      rx_count = '0;
    end
  endtask

  task automatic send_frame(input logic typed, input result_t want);
    for (int i = 0; i < frame_buf.size(); i++)
      send_byte(frame_buf[i], i == frame_buf.size() - 1, typed, want);
  endtask

  // Stops the sender and waits until every reply is in and the pipeline is empty.
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    while (pending_replies.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_setup(input logic [7:0] addr, input logic [7:0] func);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= CfgExpAddress;
    cfg_wdata_i <= addr;
    @(posedge clk_i);
    cfg_index_i <= CfgExpFunction;
    cfg_wdata_i <= func;
    @(posedge clk_i);
    cfg_we_i  <= 1'b0;
    want_addr = addr;
    want_func = func;
  endtask

  // Builds a reply frame for the current setup: mostly well formed with
  // random content, some with a wrong length, header or check byte, and
  // some of random length around the bounds and beyond saturation.
  task automatic build_reply_frame();
    logic [7:0]  head [HeadBytes];
    int unsigned len;
    int unsigned pick;
    for (int i = 0; i < HeadBytes; i++) head[i] = 8'($urandom_range(0, 255));
    pick = $urandom_range(0, 99);
    if ($urandom_range(0, 24) != 0) head[0] = want_addr;
    if ($urandom_range(0, 24) != 0) head[1] = want_func;
    case (want_func)
      CodeOptions:  len = 5;
      CodeStatus:   len = 4;
      CodePosition: begin
        len = 8;
        if ($urandom_range(0, 4) != 0) head[2] = 8'($urandom_range(0, 1));
      end
      CodeVersion:  len = 7;
      CodeMove, CodeStop: begin
        len = 4;
        case ($urandom_range(0, 3))
          0: head[2] = ReplyAck;
          1: head[2] = ReplyReached;
          default: ;
        endcase
      end
      default: len = $urandom_range(4, 8);
    endcase
    if ($urandom_range(0, 6) == 0) begin
      len     = 4;
      head[2] = $urandom_range(0, 1) ? DevParamErr : DevFormatErr;
    end
    if (pick < 8) begin
      len = $urandom_range(0, 1) ? len + 1 : len - 1;
    end else if (pick < 20) begin
      case ($urandom_range(0, 3))
        0: len = $urandom_range(1, 3);
        1: len = $urandom_range(MaxFrameBytes - 1, MaxFrameBytes + 1);
        2: len = $urandom_range(62, 70);
        default: len = $urandom_range(1, 12);
      endcase
    end
    frame_buf.delete();
    for (int i = 0; i < len; i++)
      frame_buf.push_back((i < HeadBytes) ? head[i] : 8'($urandom_range(0, 255)));
    frame_buf[len - 1] = ($urandom_range(0, 24) == 0) ? 8'($urandom_range(0, 255)) : CheckByte;
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $display("%0t ns: %s expected %0h, got %0h", $time, name, want, got);
      mismatches++;
    end
  endtask

  // Result checker and receiver stall pattern.
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      seen_reply.reply_address     = m_axis_tdata[7:0];
      seen_reply.reply_function    = m_axis_tdata[15:8];
      seen_reply.word_value        = m_axis_tdata[47:16];
      seen_reply.position_negative = m_axis_tdata[48];
      seen_reply.hw_family         = m_axis_tdata[52:49];
      seen_reply.hw_variant        = m_axis_tdata[56:53];
      seen_reply.hw_revision       = m_axis_tdata[64:57];
      seen_reply.frame_status      = frame_status_e'(m_axis_tuser[1:0]);
      seen_reply.reply_kind        = reply_kind_e'(m_axis_tuser[5:2]);
      if (pending_replies.size() == 0) begin
        $display("%0t ns: reply with nothing expected, got status %0d kind %0d",
                 $time, seen_reply.frame_status, seen_reply.reply_kind);
        mismatches++;
      end else begin
        oldest_reply = pending_replies.pop_front();
        check_field("frame_status", oldest_reply.frame_status, seen_reply.frame_status);
        check_field("reply_kind", oldest_reply.reply_kind, seen_reply.reply_kind);
        check_field("reply_address", oldest_reply.reply_address, seen_reply.reply_address);
        check_field("reply_function", oldest_reply.reply_function,
                    seen_reply.reply_function);
        check_field("word_value", oldest_reply.word_value, seen_reply.word_value);
        check_field("position_negative", oldest_reply.position_negative,
                    seen_reply.position_negative);
        check_field("hw_family", oldest_reply.hw_family, seen_reply.hw_family);
        check_field("hw_variant", oldest_reply.hw_variant, seen_reply.hw_variant);
        check_field("hw_revision", oldest_reply.hw_revision, seen_reply.hw_revision);
      end
    end
    // The receiver switches between stall modes in stretches of random length.
    if (mode_left == 0) begin
      stall_mode <= $urandom_range(0, 3);
      mode_left  <= $urandom_range(16, 96);
    end else begin
      mode_left <= mode_left - 1;
    end
    stall_phase <= stall_phase + 2'd1;
    case (stall_mode)
      0: m_axis_tready <= 1'b1;
      1: m_axis_tready <= ($urandom_range(0, 9) < 7);
      2: m_axis_tready <= (stall_phase == 2'd0);
      default: m_axis_tready <= ($urandom_range(0, 9) < 3);
    endcase
  end

  // Watchdog: ends the run when no transaction happens for too long.
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || cfg_we_i)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= StallLimit) begin
      $display("tb_motor_reply_frame_checker NOT OK");
      $finish;
    end
  end

  // Stimulus: directed table first, then random setup phases.
  initial begin
    logic [7:0] addr_pick;
    logic [7:0] func_pick;
    for (int i = 0; i < HeadBytes; i++) head_q[i] = 8'h00;
    tail_byte = 8'h00;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (DirTable[r]) begin
      if (DirTable[r].addr != want_addr || DirTable[r].func != want_func) begin
        settle();
        write_setup(DirTable[r].addr, DirTable[r].func);
      end
      frame_buf.delete();
      for (int i = 0; i < DirTable[r].len; i++) frame_buf.push_back(DirTable[r].bytes[8*i +: 8]);
      send_frame(DirTable[r].typed, DirTable[r].want);
    end

    while (bytes_sent < ByteTarget) begin
      settle();
      case ($urandom_range(0, 3))
        0: addr_pick = 8'h00;
        1: addr_pick = 8'hFF;
        2: addr_pick = 8'h01;
        default: addr_pick = 8'($urandom_range(0, 255));
      endcase
      case ($urandom_range(0, 8))
        0: func_pick = CodeOptions;
        1: func_pick = CodeStatus;
        2: func_pick = CodePosition;
        3: func_pick = CodeVersion;
        4: func_pick = CodeMove;
        5: func_pick = CodeStop;
        6: func_pick = 8'h00;
        7: func_pick = 8'hFF;
        default: func_pick = 8'($urandom_range(0, 255));
      endcase
      write_setup(addr_pick, func_pick);
      repeat ($urandom_range(4, 16)) begin
        build_reply_frame();
        send_frame(1'b0, '0);
      end
    end

    settle();
    if (mismatches == 0) begin
      $display("tb_motor_reply_frame_checker OK");
    end else begin
      $display("tb_motor_reply_frame_checker NOT OK");
    end
    $finish;
  end

endmodule
